// ===== design/bmp_rpu_pkg.sv =====
package bmp_rpu_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_SCALE  = 100;
	localparam int FIFO_DEPTH = 4;

	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
	localparam int SCALE_CW  = $clog2(MAX_SCALE + 1);
	localparam int SCALE_W   = 7;
	localparam int WIDTH_W   = 11;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int PIX_W     = 24;
	localparam int BYTE_W    = 8;
	localparam int PTR_W     = $clog2(FIFO_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	typedef enum logic {
		JOB_LOAD,
		JOB_EMIT
	} job_kind_t;

	typedef enum logic [1:0] {
		CMP_BLUE,
		CMP_GREEN,
		CMP_RED
	} comp_t;

	typedef struct packed {
		job_kind_t          kind;
		logic [ADDR_W-1:0]  addr;
		logic [PIX_W-1:0]   pixel;
		comp_t              comp;
		logic               is_pad;
		logic               byte_valid;
		logic               row_end;
		logic               group_end;
	} job_t;

	typedef struct packed {
		logic full;
		logic push;
	} fifo_wr_t;

	typedef struct packed {
		logic head_valid;
	} fifo_rd_t;

endpackage

// ===== design/bmp_rpu_front.sv =====
module bmp_rpu_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bmp_rpu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmp_rpu_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [bmp_rpu_pkg::PIX_W-1:0]      s_tdata,
	input  logic                               s_tuser,
	input  logic                               fifo_full,
	output logic                               push,
	output bmp_rpu_pkg::job_t                  job
);
	import bmp_rpu_pkg::*;

	logic [SCALE_W-1:0]  scale_q;
	logic [WIDTH_W-1:0]  width_q;
	logic [CNT_W-1:0]    w_eff;
	logic [SCALE_CW-1:0] s_eff;
	logic [3:0]          prod;
	logic [1:0]          prod3;
	logic [1:0]          pads;

	logic [CNT_W-1:0]    load_q, n_load;
	logic                ready_q, n_ready;
	logic [CNT_W-1:0]    pix_q, n_pix;
	logic [SCALE_CW-1:0] hrep_q, n_hrep;
	comp_t               comp_q, n_comp;
	logic [1:0]          pad_q, n_pad;
	logic [SCALE_CW-1:0] vrep_q, n_vrep;

	logic                accept;
	logic                wrap;
	logic                rend;
	logic [CNT_W-1:0]    load_inc;
	logic [SCALE_CW:0]   hinc;
	logic [SCALE_CW:0]   vinc;
	logic [2:0]          pinc;

	assign s_tready = !fifo_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		if (width_q == '0) begin
			w_eff = CNT_W'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = CNT_W'(MAX_WIDTH);
		end else begin
			w_eff = CNT_W'(width_q);
		end
		if (scale_q == '0) begin
			s_eff = SCALE_CW'(1);
		end else if (int'(scale_q) > MAX_SCALE) begin
			s_eff = SCALE_CW'(MAX_SCALE);
		end else begin
			s_eff = SCALE_CW'(scale_q);
		end
	end

	// Only the low two bits of width and scale decide the padding of a row.
	assign prod  = {2'b00, w_eff[1:0]} * {2'b00, s_eff[1:0]};
	assign prod3 = prod[1:0] + {prod[0], 1'b0};
	assign pads  = 2'd0 - prod3;

	always_comb begin
		n_load   = load_q;
		n_ready  = ready_q;
		n_pix    = pix_q;
		n_hrep   = hrep_q;
		n_comp   = comp_q;
		n_pad    = pad_q;
		n_vrep   = vrep_q;
		push     = 1'b0;
		job      = '0;
		rend     = 1'b0;
		wrap     = !(comp_q == CMP_BLUE || comp_q == CMP_GREEN);
		load_inc = load_q + CNT_W'(1);
		hinc     = {1'b0, hrep_q} + (SCALE_CW+1)'(1);
		vinc     = {1'b0, vrep_q} + (SCALE_CW+1)'(1);
		pinc     = {1'b0, pad_q} + 3'd1;

		if (accept) begin
			if (s_tuser == OP_LOAD) begin
				if (!ready_q) begin
					push      = 1'b1;
					job.kind  = JOB_LOAD;
					job.addr  = load_q[ADDR_W-1:0];
					job.pixel = s_tdata;
					if (load_inc >= w_eff) begin
						n_ready = 1'b1;
						n_load  = '0;
						n_pix   = '0;
						n_hrep  = '0;
						n_comp  = CMP_BLUE;
						n_pad   = '0;
						n_vrep  = '0;
					end else begin
						n_load = load_inc;
					end
				end
			end else begin
				push     = 1'b1;
				job.kind = JOB_EMIT;
				if (ready_q) begin
					job.byte_valid = 1'b1;
					if (pix_q < w_eff) begin
						job.addr = pix_q[ADDR_W-1:0];
						job.comp = wrap ? CMP_RED : comp_q;
						if (wrap) begin
							n_comp = CMP_BLUE;
							if (hinc >= {1'b0, s_eff}) begin
								n_hrep = '0;
								n_pix  = pix_q + CNT_W'(1);
							end else begin
								n_hrep = hinc[SCALE_CW-1:0];
							end
						end else begin
							n_comp = (comp_q == CMP_BLUE) ? CMP_GREEN : CMP_RED;
						end
						rend = (n_pix >= w_eff) && (pads == 2'd0);
					end else begin
						job.is_pad = 1'b1;
						n_pad      = pinc[1:0];
						rend       = pinc >= {1'b0, pads};
					end
					if (rend) begin
						n_pix  = '0;
						n_hrep = '0;
						n_comp = CMP_BLUE;
						n_pad  = '0;
						if (vinc >= {1'b0, s_eff}) begin
							job.group_end = 1'b1;
							n_vrep  = '0;
							n_ready = 1'b0;
							n_load  = '0;
						end else begin
							n_vrep = vinc[SCALE_CW-1:0];
						end
					end
					job.row_end = rend;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_W'(1);
			width_q <= WIDTH_W'(1);
			load_q  <= '0;
			ready_q <= 1'b0;
			pix_q   <= '0;
			hrep_q  <= '0;
			comp_q  <= CMP_BLUE;
			pad_q   <= '0;
			vrep_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SCALE: scale_q <= cfg_wdata[SCALE_W-1:0];
					REG_WIDTH: width_q <= cfg_wdata[WIDTH_W-1:0];
					default: ;
				endcase
			end
			load_q  <= n_load;
			ready_q <= n_ready;
			pix_q   <= n_pix;
			hrep_q  <= n_hrep;
			comp_q  <= n_comp;
			pad_q   <= n_pad;
			vrep_q  <= n_vrep;
		end
	end

endmodule

// ===== design/bmp_rpu_fifo.sv =====
module bmp_rpu_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bmp_rpu_pkg::fifo_wr_t  wr,
	input  bmp_rpu_pkg::job_t      wr_job,
	output logic                   full,
	output bmp_rpu_pkg::fifo_rd_t  rd,
	input  logic                   pop,
	output bmp_rpu_pkg::job_t      head
);
	import bmp_rpu_pkg::*;

	job_t             fifo_mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             head_valid;
	logic             do_push;
	logic             do_pop;

	assign full       = cnt_q == (PTR_W+1)'(FIFO_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = fifo_mem[rd_ptr_q];
	assign do_push    = wr.push && !wr.full;
	assign do_pop     = pop && head_valid;

	assign rd.head_valid = head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_mem[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (PTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/bmp_rpu_back.sv =====
module bmp_rpu_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bmp_rpu_pkg::fifo_rd_t           rd,
	input  bmp_rpu_pkg::job_t               head,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bmp_rpu_pkg::BYTE_W-1:0]  m_tdata,
	output logic                            m_tlast,
	output logic [1:0]                      m_tuser
);
	import bmp_rpu_pkg::*;

	logic [PIX_W-1:0]  store_mem [MAX_WIDTH];
	logic [PIX_W-1:0]  rd_s1;
	job_t              job_s1;
	logic              vld_s1;
	logic              out_vld_q;
	logic [BYTE_W-1:0] byte_q;
	logic              row_end_q;
	logic              group_end_q;
	logic              byte_valid_q;
	logic              adv_out;
	logic              s1_free;
	logic              pop_rd;
	logic [BYTE_W-1:0] byte_s1;

	assign adv_out = !out_vld_q || m_tready;
	assign s1_free = !vld_s1 || adv_out;
	// Store writes need no output slot, so they drain even while the output stalls.
	assign pop     = rd.head_valid && (head.kind == JOB_LOAD || s1_free);
	assign pop_rd  = rd.head_valid && head.kind == JOB_EMIT && s1_free;

	always_ff @(posedge clk) begin
		if (pop && head.kind == JOB_LOAD) begin
			store_mem[head.addr] <= head.pixel;
		end
		if (pop_rd) begin
			rd_s1  <= store_mem[head.addr];
			job_s1 <= head;
		end
	end

	always_comb begin
		byte_s1 = '0;
		if (job_s1.byte_valid && !job_s1.is_pad) begin
			case (job_s1.comp)
				CMP_BLUE:  byte_s1 = rd_s1[7:0];
				CMP_GREEN: byte_s1 = rd_s1[15:8];
				CMP_RED:   byte_s1 = rd_s1[23:16];
				default:   byte_s1 = rd_s1[23:16];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && vld_s1) begin
			byte_q       <= byte_s1;
			byte_valid_q <= job_s1.byte_valid;
			row_end_q    <= job_s1.row_end;
			group_end_q  <= job_s1.group_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s1_free) begin
				vld_s1 <= pop_rd;
			end
			if (adv_out) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = byte_q;
	assign m_tlast  = row_end_q;
	assign m_tuser  = {group_end_q, byte_valid_q};

endmodule

// ===== design/bmp_row_pixel_replicating_upscaler_top.sv =====
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_we               cfg_index, cfg_wdata (scale, width)
// s         in         s_tvalid / s_tready  s_tdata, s_tuser (opcode)
// m         out        m_tvalid / m_tready  m_tdata, m_tlast, m_tuser
//
// One item is accepted per clock unless the queue is full; emit bytes are registered.
// The per-item counter update in the front stage sets the one-item-per-cycle rate,
// and the single-port line store is read once per emitted byte.
// Reset clears all counters and the queue; the line store has no clearing pass.
// A stalled output holds the byte while a four-entry queue keeps taking items until it is full.
module bmp_row_pixel_replicating_upscaler_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bmp_rpu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmp_rpu_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [bmp_rpu_pkg::PIX_W-1:0]      s_tdata,  // blue[7:0], green[15:8], red[23:16]
	input  logic                               s_tuser,  // opcode
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [bmp_rpu_pkg::BYTE_W-1:0]     m_tdata,  // out_byte[7:0]
	output logic                               m_tlast,  // row_end
	output logic [1:0]                         m_tuser   // byte_valid[0], group_end[1]
);
	import bmp_rpu_pkg::*;

	logic     push;
	logic     fifo_full;
	logic     pop;
	job_t     push_job;
	job_t     head;
	fifo_wr_t wr;
	fifo_rd_t rd;

	assign wr.full = fifo_full;
	assign wr.push = push;

	bmp_rpu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.fifo_full (fifo_full),
		.push      (push),
		.job       (push_job)
	);

	bmp_rpu_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.wr_job     (push_job),
		.full       (fifo_full),
		.rd         (rd),
		.pop        (pop),
		.head       (head)
	);

	bmp_rpu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd       (rd),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== design/bmp_rpu_checker.sv =====
module bmp_rpu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [1:0] m_tuser
);

	// A request with no stored row carries nothing but the invalid flag.
	a_invalid_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00 && !m_tlast && !m_tuser[1])
		else $error("invalid result carries data or end flags");

	// The last repetition of a row always ends a row of valid bytes.
	a_group_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && m_tuser[0])
		else $error("group end without row end");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output transaction dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("output payload changed while stalled");

endmodule

bind bmp_row_pixel_replicating_upscaler_top bmp_rpu_checker u_bmp_rpu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

// ===== tb/tb_bmp_row_pixel_replicating_upscaler_top.sv =====
module tb_bmp_row_pixel_replicating_upscaler_top;
	import bmp_rpu_pkg::*;

	localparam int SETTLE_CYCLES = 10;

	typedef struct packed {
		logic [7:0] value;
		logic       valid;
		logic       row_end;
		logic       group_end;
	} scaled_byte_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SCALE;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [PIX_W-1:0]     s_tdata = '0;
	logic                 s_tuser = OP_LOAD;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [BYTE_W-1:0]    m_tdata;
	logic                 m_tlast;
	logic [1:0]           m_tuser;

	// Shadow of the upscaler state.
	logic [PIX_W-1:0] line_mem [0:MAX_WIDTH-1];
	logic [6:0]       scale_reg = 7'd1;
	logic [10:0]      width_reg = 11'd1;
	int unsigned      loaded, pix, hrep, comp, padn, vrep;
	bit               row_held;
	int unsigned      hi_water;

	scaled_byte_t     due_bytes[$];
	scaled_byte_t     got, want;
	int               mismatches;
	int               gap_pct, stall_pct;

	bmp_row_pixel_replicating_upscaler_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned used_scale();
		if (scale_reg == 0) return 1;
		if (scale_reg > MAX_SCALE) return MAX_SCALE;
		return scale_reg;
	endfunction

	function automatic int unsigned used_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic void upscale_step(input logic op, input logic [PIX_W-1:0] px);
		int unsigned w, s, pads, c;
		logic [PIX_W-1:0] word;
		scaled_byte_t r;
		w = used_width();
		s = used_scale();
		pads = (4 - ((w * s * 3) & 3)) & 3;
		r = '0;
		if (op == OP_LOAD) begin
			if (row_held) return;
			if (loaded < MAX_WIDTH) begin
				line_mem[loaded] = px;
				if (loaded + 1 > hi_water) hi_water = loaded + 1;
			end
			loaded++;
			if (loaded >= w) begin
				row_held = 1;
				loaded = 0;
				pix = 0;
				hrep = 0;
				comp = 0;
				padn = 0;
				vrep = 0;
			end
			return;
		end
		if (!row_held) begin
			due_bytes.push_back(r);
			return;
		end
		r.valid = 1'b1;
		if (pix < w) begin
			c = (comp > 2) ? 2 : comp;
			word = line_mem[pix];
			r.value = word[8*c +: 8];
			comp = c + 1;
			if (comp >= 3) begin
				comp = 0;
				hrep++;
				if (hrep >= s) begin
					hrep = 0;
					pix++;
				end
			end
			if (pix >= w && pads == 0) r.row_end = 1'b1;
		end else begin
			// Pad stage; with no padding due it still sends one zero byte.
			padn++;
			if (padn >= pads) r.row_end = 1'b1;
		end
		if (r.row_end) begin
			pix = 0;
			hrep = 0;
			comp = 0;
			padn = 0;
			vrep++;
			if (vrep >= s) begin
				r.group_end = 1'b1;
				vrep = 0;
				row_held = 0;
				loaded = 0;
			end
		end
		due_bytes.push_back(r);
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			got = {m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
			if (due_bytes.size() == 0) begin
				$display("%0t: unexpected transaction byte %h valid %b row_end %b group_end %b",
					$time, got.value, got.valid, got.row_end, got.group_end);
				mismatches++;
			end else begin
				want = due_bytes.pop_front();
				if (got !== want) begin
					$display("%0t: expected byte %h valid %b row_end %b group_end %b",
						$time, want.value, want.valid, want.row_end, want.group_end);
					$display("%0t: actual   byte %h valid %b row_end %b group_end %b",
						$time, got.value, got.valid, got.row_end, got.group_end);
					mismatches++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_item(input logic op, input logic [PIX_W-1:0] px);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < gap_pct) gap++;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		upscale_step(op, px);
	endtask

	// Loads give no output, so a settling wait lets them land before a register write.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (due_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [6:0] scale, input logic [10:0] width);
		logic [3:0] junk;
		junk = $urandom;
		cfg_we <= 1'b1;
		cfg_index <= REG_SCALE;
		cfg_wdata <= {junk, scale};
		@(posedge clk);
		cfg_index <= REG_WIDTH;
		cfg_wdata <= width;
		@(posedge clk);
		cfg_we <= 1'b0;
		scale_reg = scale;
		width_reg = width;
	endtask

	task automatic fill_row();
		while (!row_held) send_item(OP_LOAD, $urandom);
	endtask

	task automatic empty_row();
		while (row_held) send_item(OP_EMIT, $urandom);
	endtask

	// Shrinking scale and width first ends a held row within a few bytes.
	task automatic drop_row();
		wait_idle();
		set_config(7'd1, 11'd1);
		empty_row();
	endtask

	task automatic test_no_row_and_defaults();
		send_item(OP_EMIT, 24'h000000);
		send_item(OP_EMIT, 24'hFFFFFF);
		send_item(OP_LOAD, 24'h80FF01);
		empty_row();
		send_item(OP_EMIT, $urandom);
	endtask

	task automatic test_clamped_config();
		wait_idle();
		set_config(7'd0, 11'd0);
		send_item(OP_LOAD, 24'hFFFFFF);
		send_item(OP_LOAD, 24'h123456);
		empty_row();
		wait_idle();
		set_config(7'd2, 11'd2);
		send_item(OP_LOAD, 24'h000000);
		send_item(OP_LOAD, 24'hFFFFFF);
		repeat (5) send_item(OP_EMIT, $urandom);
		send_item(OP_LOAD, 24'hA5A5A5);
		empty_row();
	endtask

	task automatic test_mid_row_config();
		wait_idle();
		set_config(7'd1, 11'd5);
		repeat (2) send_item(OP_LOAD, $urandom);
		wait_idle();
		// The load count already equals the new width: the next load ends the row.
		set_config(7'd1, 11'd2);
		send_item(OP_LOAD, $urandom);
		repeat (3) send_item(OP_EMIT, $urandom);
		wait_idle();
		set_config(7'd4, 11'd1);
		empty_row();
	endtask

	task automatic test_scale_limit();
		drop_row();
		wait_idle();
		// A scale above the limit acts as the limit, so the first row ends on byte 300.
		set_config(7'd127, 11'd1);
		send_item(OP_LOAD, $urandom);
		repeat (300) send_item(OP_EMIT, $urandom);
		wait_idle();
		set_config(7'd3, 11'd1);
		empty_row();
	endtask

	task automatic test_full_width();
		drop_row();
		wait_idle();
		set_config(7'd1, 11'd2047);
		repeat (12) send_item(OP_LOAD, $urandom);
		wait_idle();
		set_config(7'd3, 11'd4);
		send_item(OP_LOAD, $urandom);
		empty_row();
	endtask

	task automatic test_random_rows(input int unsigned count);
		int unsigned done;
		logic op;
		logic [6:0] new_scale;
		logic [10:0] new_width;
		done = 0;
		while (done < count) begin
			if ($urandom_range(99) < 3) begin
				case ($urandom_range(9))
					0: new_scale = 7'd0;
					1, 2: new_scale = $urandom_range(6, 4);
					default: new_scale = $urandom_range(3, 1);
				endcase
				case ($urandom_range(9))
					0: new_width = 11'd0;
					1, 2: new_width = $urandom_range(16, 7);
					default: new_width = $urandom_range(6, 1);
				endcase
				// A held row must never be read past the entries written so far.
				if (row_held && new_width > hi_water) new_width = hi_water;
				wait_idle();
				set_config(new_scale, new_width);
			end
			if (row_held) op = ($urandom_range(99) < 92) ? OP_EMIT : OP_LOAD;
			else op = ($urandom_range(99) < 88) ? OP_LOAD : OP_EMIT;
			if (op == OP_EMIT || !row_held) done++;
			send_item(op, $urandom);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 0;
		stall_pct = 0;
		test_no_row_and_defaults();
		test_clamped_config();
		test_mid_row_config();
		test_random_rows(40);
		gap_pct = 71;
		test_random_rows(40);
		gap_pct = 0;
		stall_pct = 71;
		test_scale_limit();
		test_random_rows(40);
		gap_pct = 32;
		stall_pct = 32;
		test_full_width();
		test_random_rows(40);
		wait_idle();
		if (mismatches == 0 && due_bytes.size() == 0) begin
			$display("tb_bmp_row_pixel_replicating_upscaler_top OK");
		end else begin
			$display("tb_bmp_row_pixel_replicating_upscaler_top NOT OK");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("tb_bmp_row_pixel_replicating_upscaler_top NOT OK");
		$finish;
	end

endmodule
